// ----- hw/rtl/slc_pkg.sv -----
// Shared types, constants and helpers of the cache tag model.
`default_nettype none
package slc_pkg;

  localparam int LINE_COUNT = 512;
  localparam int LINE_BYTES = 32;
  localparam int IDX_W      = 9;
  localparam int OFF_W      = 5;
  localparam int TAG_W      = 32 - OFF_W;
  localparam int RANK_W     = 9;
  localparam int PADDR_W    = 4;
  localparam int ENTRY_W    = 1 + TAG_W + RANK_W;

  localparam logic [3:0]        LOG_LINES = 4'd9;
  localparam logic [RANK_W-1:0] RANK_MAX  = 9'h1FF;

  localparam logic [1:0] REG_WAYS_LOG2      = 2'd0;
  localparam logic [1:0] REG_WRITE_ALLOCATE = 2'd1;
  localparam logic [1:0] REG_PREFETCH_MODE  = 2'd2;

  localparam logic [1:0] PF_NONE = 2'd0;
  localparam logic [1:0] PF_MISS = 2'd1;

  typedef struct packed {
    logic        action;
    logic [31:0] address;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] hit_count;
  } rsp_t;

  typedef struct packed {
    logic              valid;
    logic [TAG_W-1:0]  tag;
    logic [RANK_W-1:0] rank;
  } entry_t;

  typedef struct packed {
    logic [3:0] ways_log2;
    logic       write_allocate;
    logic [1:0] prefetch_mode;
  } cfg_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic scan_issue;
    logic upd_issue;
    logic decide;
    logic demand_done;
    logic start_pf;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic issue_last;
    logic need_upd;
    logic need_pf;
    logic is_pf;
    logic out_free;
  } sts_t;

  // Line index of a way within the set that the address selects.
  function automatic logic [IDX_W-1:0] line_index(logic [31:0] a, logic [3:0] wl,
                                                  logic [IDX_W-1:0] way);
    logic [IDX_W-1:0] set;
    set = a[OFF_W +: IDX_W] & (RANK_MAX >> wl);
    return (set << wl) | way;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/slc_ram.sv -----
// Generic simple dual-port RAM with a registered read.
`default_nettype none
module slc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/slc_ctrl.sv -----
// Sequencer of the cache lookup: clearing sweep, scan, update and prefetch.
`default_nettype none
module slc_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output      logic          req_stall,
  input  wire slc_pkg::sts_t sts,
  output      slc_pkg::cmd_t cmd
);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_SCAN   = 4'd2;
  localparam logic [3:0] S_STAIL  = 4'd3;
  localparam logic [3:0] S_DECIDE = 4'd4;
  localparam logic [3:0] S_UPD    = 4'd5;
  localparam logic [3:0] S_UTAIL  = 4'd6;
  localparam logic [3:0] S_POST   = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  assign req_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (sts.issue_last) state_next = S_STAIL;
      end
      S_STAIL: state_next = S_DECIDE;
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = sts.need_upd ? S_UPD : S_POST;
      end
      S_UPD: begin
        cmd.upd_issue = 1'b1;
        if (sts.issue_last) state_next = S_UTAIL;
      end
      S_UTAIL: state_next = S_POST;
      S_POST: begin
        if (sts.is_pf) begin
          state_next = S_DONE;
        end else begin
          cmd.demand_done = 1'b1;
          if (sts.need_pf) begin
            cmd.start_pf = 1'b1;
            state_next   = S_SCAN;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/slc_dp.sv -----
// Datapath: line RAM, way counter, lookup accumulators, hit counter and result register.
`default_nettype none
module slc_dp (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire slc_pkg::cfg_t cfg,
  input  wire slc_pkg::req_t req,
  output      slc_pkg::rsp_t rsp,
  output      logic          rsp_valid,
  input  wire logic          rsp_stall,
  input  wire slc_pkg::cmd_t cmd,
  output      slc_pkg::sts_t sts
);

  logic [3:0]                  wl;
  logic [slc_pkg::IDX_W-1:0]   set_mask;
  logic [slc_pkg::IDX_W-1:0]   ways_m1;
  logic [31:0]                 dem_addr;
  logic [31:0]                 look_addr;
  logic                        alloc;
  logic                        is_pf;
  logic [slc_pkg::TAG_W-1:0]   look_tag;
  logic [slc_pkg::IDX_W-1:0]   cnt;
  logic [slc_pkg::IDX_W-1:0]   clr_cnt;
  logic                        rd_vld;
  logic                        rd_upd;
  logic [slc_pkg::IDX_W-1:0]   rd_way;
  slc_pkg::entry_t             ent;
  logic                        found;
  logic [slc_pkg::IDX_W-1:0]   hit_way;
  logic [slc_pkg::RANK_W-1:0]  hit_rank;
  logic                        inv_found;
  logic [slc_pkg::IDX_W-1:0]   inv_way;
  logic [slc_pkg::IDX_W-1:0]   vic_way;
  logic [slc_pkg::RANK_W-1:0]  vic_rank;
  logic [slc_pkg::IDX_W-1:0]   tgt;
  logic [slc_pkg::RANK_W-1:0]  thr;
  logic                        dem_hit;
  logic [31:0]                 hits_total;
  logic                        re;
  logic [slc_pkg::IDX_W-1:0]   raddr;
  logic                        we;
  logic [slc_pkg::IDX_W-1:0]   waddr;
  slc_pkg::entry_t             wdata;
  logic [slc_pkg::ENTRY_W-1:0] rdata;

  assign wl       = (cfg.ways_log2 > slc_pkg::LOG_LINES) ? slc_pkg::LOG_LINES : cfg.ways_log2;
  assign set_mask = slc_pkg::RANK_MAX >> wl;
  assign ways_m1  = slc_pkg::RANK_MAX >> (slc_pkg::LOG_LINES - wl);
  // The tag keeps the line bits above the set field of the current geometry.
  assign look_tag = {look_addr[31:slc_pkg::OFF_W+slc_pkg::IDX_W],
                     look_addr[slc_pkg::OFF_W +: slc_pkg::IDX_W] & ~set_mask};
  assign ent      = slc_pkg::entry_t'(rdata);

  assign re    = cmd.scan_issue | cmd.upd_issue;
  assign raddr = slc_pkg::line_index(look_addr, wl, cnt);

  always_comb begin
    we    = 1'b0;
    waddr = clr_cnt;
    wdata = '0;
    if (cmd.clear) begin
      we = 1'b1;
    end else if (rd_vld && rd_upd) begin
      we    = 1'b1;
      waddr = slc_pkg::line_index(look_addr, wl, rd_way);
      wdata = ent;
      if (rd_way == tgt) begin
        wdata.valid = 1'b1;
        wdata.tag   = look_tag;
        wdata.rank  = '0;
      end else if (ent.valid && ent.rank < thr) begin
        wdata.rank = ent.rank + 1'b1;
      end
    end
  end

  slc_ram #(
    .WIDTH(slc_pkg::ENTRY_W),
    .DEPTH(slc_pkg::LINE_COUNT)
  ) u_lines (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign sts.clear_last = (clr_cnt == slc_pkg::RANK_MAX);
  assign sts.issue_last = (cnt == ways_m1);
  assign sts.need_upd   = found | alloc;
  assign sts.need_pf    = !is_pf && (cfg.prefetch_mode[1] ||
                          (cfg.prefetch_mode == slc_pkg::PF_MISS && !found));
  assign sts.is_pf      = is_pf;
  assign sts.out_free   = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt    <= '0;
      rd_vld     <= 1'b0;
      rd_upd     <= 1'b0;
      hits_total <= '0;
      rsp_valid  <= 1'b0;
      cnt        <= '0;
      found      <= 1'b0;
      inv_found  <= 1'b0;
      is_pf      <= 1'b0;
    end else begin
      if (cmd.clear) clr_cnt <= clr_cnt + 1'b1;
      rd_vld <= re;
      rd_upd <= cmd.upd_issue;
      rd_way <= cnt;

      if (cmd.load || cmd.start_pf || cmd.decide) begin
        cnt <= '0;
      end else if (re) begin
        cnt <= cnt + 1'b1;
      end

      if (cmd.load) begin
        dem_addr  <= req.address;
        look_addr <= req.address;
        alloc     <= !req.action || cfg.write_allocate;
        is_pf     <= 1'b0;
      end else if (cmd.start_pf) begin
        look_addr <= dem_addr + 32'(slc_pkg::LINE_BYTES);
        alloc     <= 1'b1;
        is_pf     <= 1'b1;
      end

      if (cmd.load || cmd.start_pf) begin
        found     <= 1'b0;
        inv_found <= 1'b0;
      end else if (rd_vld && !rd_upd) begin
        if (ent.valid && ent.tag == look_tag && !found) begin
          found    <= 1'b1;
          hit_way  <= rd_way;
          hit_rank <= ent.rank;
        end
        if (!ent.valid && !inv_found) begin
          inv_found <= 1'b1;
          inv_way   <= rd_way;
        end
        // Strictly greater keeps the lowest way on a tie.
        if (rd_way == '0 || ent.rank > vic_rank) begin
          vic_way  <= rd_way;
          vic_rank <= ent.rank;
        end
      end

      if (cmd.decide) begin
        if (found) begin
          tgt <= hit_way;
          thr <= hit_rank;
        end else if (inv_found) begin
          tgt <= inv_way;
          thr <= slc_pkg::RANK_MAX;
        end else begin
          tgt <= vic_way;
          thr <= vic_rank;
        end
      end

      if (cmd.demand_done) begin
        dem_hit    <= found;
        hits_total <= hits_total + {31'd0, found};
      end

      if (cmd.emit) begin
        rsp_valid     <= 1'b1;
        rsp.hit       <= dem_hit;
        rsp.hit_count <= hits_total;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  a_count_only_on_demand: assert property (@(posedge clk) disable iff (rst)
    !cmd.demand_done |=> $stable(hits_total))
    else $error("hit counter moved outside a demand completion");

  a_no_port_collision: assert property (@(posedge clk) disable iff (rst)
    (we && re) |-> (waddr != raddr))
    else $error("line RAM read and written at the same index");

  a_clear_alone: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |-> !(re || rd_vld))
    else $error("lookup overlaps the clearing sweep");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!rsp_valid || !rsp_stall))
    else $error("result overwritten before it was taken");

endmodule
`default_nettype wire

// ----- hw/rtl/set_assoc_lru_cache_tags.sv -----
// Cache tag model: with W = 2^ways_log2 ways and one RAM read a cycle, a lookup scans the set,
// decides on a target way and updates the ranks; a miss that does not allocate skips the update.
// A result is emitted after the demand lookup and, when one runs, a prefetch lookup of the next line;
// a new beat is taken only once that result is emitted, so the lookups of two beats never overlap.
// After reset a sweep clears the line RAM; no beat is accepted until it ends.
// Configuration registers reset to two ways, write allocate on and no prefetch.
`default_nettype none
module set_assoc_lru_cache_tags (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         req_valid,
  output      logic                         req_stall,
  input  wire slc_pkg::req_t                req,
  output      logic                         rsp_valid,
  input  wire logic                         rsp_stall,
  output      slc_pkg::rsp_t                rsp,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [slc_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [31:0]                  pwdata,
  output      logic [31:0]                  prdata,
  output      logic                         pready
);

  slc_pkg::cfg_t cfg;
  slc_pkg::cmd_t cmd;
  slc_pkg::sts_t sts;
  logic [1:0]    reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ways_log2      <= 4'd1;
      cfg.write_allocate <= 1'b1;
      cfg.prefetch_mode  <= slc_pkg::PF_NONE;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        slc_pkg::REG_WAYS_LOG2:      cfg.ways_log2      <= pwdata[3:0];
        slc_pkg::REG_WRITE_ALLOCATE: cfg.write_allocate <= pwdata[0];
        slc_pkg::REG_PREFETCH_MODE:  cfg.prefetch_mode  <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      slc_pkg::REG_WAYS_LOG2:      prdata = {28'd0, cfg.ways_log2};
      slc_pkg::REG_WRITE_ALLOCATE: prdata = {31'd0, cfg.write_allocate};
      slc_pkg::REG_PREFETCH_MODE:  prdata = {30'd0, cfg.prefetch_mode};
      default:                     prdata = '0;
    endcase
  end

  slc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  slc_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .req      (req),
    .rsp      (rsp),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule
`default_nettype wire
